// ----- hw/rtl/hdip_pkg.sv -----
// Shared types, codes and constants of the HID descriptor item parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package hdip_pkg;

   localparam int unsigned StackDepthDef = 8;
   localparam int unsigned MaxNestDef    = 15;
   localparam int unsigned NumGlobals    = 10;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
   localparam int unsigned QueueCountW   = $clog2(QueueDepth + 1);
   localparam int unsigned RspDataW      = 192;

   localparam logic [7:0] LongPrefix = 8'hfe;

   // item type codes
   localparam logic [1:0] TypeMain   = 2'd0;
   localparam logic [1:0] TypeGlobal = 2'd1;
   localparam logic [1:0] TypeLocal  = 2'd2;
   localparam logic [1:0] TypeRsv    = 2'd3;

   // short item tags
   localparam logic [3:0] TagCollection = 4'ha;
   localparam logic [3:0] TagEndColl    = 4'hc;
   localparam logic [3:0] TagPush       = 4'ha;
   localparam logic [3:0] TagPop        = 4'hb;

   // global slots shown on every result
   localparam int unsigned GlobUsagePage  = 0;
   localparam int unsigned GlobReportSize = 7;
   localparam int unsigned GlobReportId   = 8;
   localparam int unsigned GlobReportCnt  = 9;

   typedef enum logic [2:0] {
      StOk    = 3'd0,
      StLong  = 3'd1,
      StRsv   = 3'd2,
      StUnder = 3'd3,
      StOver  = 3'd4,
      StTrunc = 3'd5
   } status_type;

   // one finished (or cut-off) item handed from front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tag;
      logic [7:0]  size;
      logic [31:0] value;
      logic        apply;   // complete short item: update globals, stack, nesting
      status_type  status;
      logic        last;
   } rec_type;

   function automatic logic [2:0] short_size(input logic [1:0] code);
      return (code == 2'd3) ? 3'd4 : {1'b0, code};
   endfunction

endpackage

// ----- hw/rtl/hdip_front.sv -----
// Byte front end: walks the descriptor byte stream and assembles items.
// Depends on hdip_pkg for the item record and codes.
module hdip_front
   import hdip_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       in_ready,
   output logic       rec_valid,
   output rec_type    rec,
   input  logic       rec_ready
);

   typedef enum logic [4:0] {
      PhPrefix = 5'b00001,
      PhSdata  = 5'b00010,
      PhLsize  = 5'b00100,
      PhLtag   = 5'b01000,
      PhLpay   = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  ltag_ff, ltag_in;
   logic [7:0]  lsize_ff, lsize_in;

   logic        accept;
   logic        complete;
   logic        long_done;
   logic [2:0]  sz;
   logic [31:0] acc_new;

   assign in_ready = rec_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      phase_in  = phase_ff;
      prefix_in = prefix_ff;
      left_in   = left_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      ltag_in   = ltag_ff;
      lsize_in  = lsize_ff;
      complete  = 1'b0;
      long_done = 1'b0;
      sz        = short_size(in_byte[1:0]);
      acc_new   = acc_ff | (32'(in_byte) << {idx_ff, 3'b000});
      rec       = '0;
      rec.last  = in_last;

      unique case (phase_ff)
         PhPrefix: begin
            prefix_in = in_byte;
            acc_in    = '0;
            idx_in    = '0;
            if (in_byte == LongPrefix) begin
               phase_in = PhLsize;
               rec.kind = TypeRsv;
            end else begin
               left_in   = 8'(sz);
               rec.kind  = in_byte[3:2];
               rec.tag   = {4'b0000, in_byte[7:4]};
               rec.size  = 8'(sz);
               if (sz == 3'd0) begin
                  complete = 1'b1;
               end else begin
                  phase_in = PhSdata;
               end
            end
         end
         PhSdata: begin
            acc_in    = acc_new;
            idx_in    = idx_ff + 2'd1;
            left_in   = left_ff - 8'd1;
            rec.kind  = prefix_ff[3:2];
            rec.tag   = {4'b0000, prefix_ff[7:4]};
            rec.size  = 8'(short_size(prefix_ff[1:0]));
            rec.value = acc_new;
            complete  = (left_ff == 8'd1);
         end
         PhLsize: begin
            lsize_in = in_byte;
            left_in  = in_byte;
            phase_in = PhLtag;
            rec.kind = TypeRsv;
            rec.size = in_byte;
         end
         PhLtag: begin
            ltag_in  = in_byte;
            rec.kind = TypeRsv;
            rec.tag  = in_byte;
            rec.size = lsize_ff;
            if (left_ff == 8'd0) begin
               long_done = 1'b1;
            end else begin
               phase_in = PhLpay;
            end
         end
         PhLpay: begin
            left_in   = left_ff - 8'd1;
            rec.kind  = TypeRsv;
            rec.tag   = ltag_ff;
            rec.size  = lsize_ff;
            long_done = (left_ff == 8'd1);
         end
         default: begin
            phase_in = PhPrefix;
         end
      endcase

      if (complete) begin
         rec.apply  = 1'b1;
         rec.status = StOk;
      end else if (long_done) begin
         rec.status = StLong;
      end else begin
         rec.status = StTrunc;
      end

      rec_valid = accept && (complete || long_done || in_last);
      if (!accept) begin
         phase_in = phase_ff;
      end else if (rec_valid) begin
         phase_in = PhPrefix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhPrefix;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prefix_ff <= prefix_in;
         left_ff   <= left_in;
         idx_ff    <= idx_in;
         acc_ff    <= acc_in;
         ltag_ff   <= ltag_in;
         lsize_ff  <= lsize_in;
      end
   end

endmodule

// ----- hw/rtl/hdip_queue.sv -----
// Short FIFO of item records between the byte front end and the back end.
// Depends on hdip_pkg for the record type and depth.
module hdip_queue
   import hdip_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  rec_type push_rec,
   output logic    push_ready,
   output logic    pop_valid,
   output rec_type pop_rec,
   input  logic    pop_ready
);

   rec_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != QueueCountW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ----- hw/rtl/hdip_back.sv -----
// Back end: applies items to globals, push/pop stack and nesting, and
// registers the result word. Depends on hdip_pkg.
module hdip_back
   import hdip_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = StackDepthDef,
   parameter int unsigned MAX_NEST    = MaxNestDef
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_valid,
   input  rec_type             rec,
   output logic                rec_ready,
   output logic                out_valid,
   output logic [RspDataW-1:0] out_data,
   output logic                out_last,
   input  logic                out_ready
);

   localparam int unsigned SpW       = $clog2(STACK_DEPTH);
   localparam int unsigned SpExtW    = (SpW > 3) ? SpW : 3;
   localparam int unsigned StackRows = STACK_DEPTH - 1;
   localparam int unsigned RowW      = (StackRows > 1) ? $clog2(StackRows) : 1;
   localparam int unsigned RowBits   = 32 * NumGlobals;
   localparam int unsigned NestW     = $clog2(MAX_NEST + 1);
   localparam int unsigned NestExtW  = (NestW > 4) ? NestW : 4;

   logic [31:0]         glob_ff [NumGlobals];
   logic [31:0]         glob_in [NumGlobals];
   logic [SpW-1:0]      sp_ff, sp_in, sp_dec;
   logic [NestW-1:0]    nest_ff, nest_in;
   logic                out_valid_ff;
   logic [RspDataW-1:0] out_data_ff, out_data_in;
   logic                out_last_ff;

   logic [RowBits-1:0]  stack_mem_ff [StackRows];
   logic [RowBits-1:0]  stack_row_ff;
   logic [RowBits-1:0]  glob_flat;
   logic [RowW-1:0]     wr_addr;
   logic [RowW-1:0]     rd_addr;
   logic                wr_en;

   logic                take;
   status_type          status;
   logic [SpExtW-1:0]   sp_ext;
   logic [NestExtW-1:0] nest_ext;

   assign rec_ready = !out_valid_ff || out_ready;
   assign take      = rec_valid && rec_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_last  = out_last_ff;

   always_comb begin
      for (int i = 0; i < NumGlobals; i++) begin
         glob_flat[32*i +: 32] = glob_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < NumGlobals; i++) begin
         glob_in[i] = glob_ff[i];
      end
      sp_in   = sp_ff;
      nest_in = nest_ff;
      wr_en   = 1'b0;
      status  = rec.status;

      if (take && rec.apply) begin
         status = StOk;
         unique case (rec.kind)
            TypeMain: begin
               if (rec.tag[3:0] == TagCollection) begin
                  if (nest_ff != NestW'(MAX_NEST)) begin
                     nest_in = nest_ff + 1'b1;
                  end
               end else if (rec.tag[3:0] == TagEndColl) begin
                  if (nest_ff != '0) begin
                     nest_in = nest_ff - 1'b1;
                  end
               end
            end
            TypeGlobal: begin
               if (rec.tag[3:0] < 4'(NumGlobals)) begin
                  for (int i = 0; i < NumGlobals; i++) begin
                     if (rec.tag[3:0] == 4'(i)) begin
                        glob_in[i] = rec.value;
                     end
                  end
               end else if (rec.tag[3:0] == TagPush) begin
                  if (sp_ff == SpW'(STACK_DEPTH - 1)) begin
                     status = StOver;
                  end else begin
                     wr_en = 1'b1;
                     sp_in = sp_ff + 1'b1;
                  end
               end else if (rec.tag[3:0] == TagPop) begin
                  if (sp_ff == '0) begin
                     status = StUnder;
                  end else begin
                     sp_in = sp_ff - 1'b1;
                     for (int i = 0; i < NumGlobals; i++) begin
                        glob_in[i] = stack_row_ff[32*i +: 32];
                     end
                  end
               end
            end
            TypeLocal: begin
               status = StOk;
            end
            TypeRsv: begin
               status = StRsv;
            end
            default: begin
               status = StOk;
            end
         endcase
      end
   end

   // keep the row under the top of stack registered for a pop next cycle
   assign sp_dec  = sp_in - 1'b1;
   assign rd_addr = sp_dec[RowW-1:0];
   assign wr_addr = sp_ff[RowW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= glob_flat;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         stack_row_ff <= glob_flat;
      end else begin
         stack_row_ff <= stack_mem_ff[rd_addr];
      end
   end

   assign sp_ext   = SpExtW'(sp_in);
   assign nest_ext = NestExtW'(nest_in);

   always_comb begin
      out_data_in = {4'b0000,
                     glob_in[GlobReportCnt],
                     glob_in[GlobReportSize],
                     glob_in[GlobReportId],
                     glob_in[GlobUsagePage],
                     status,
                     sp_ext[2:0],
                     nest_ext[3:0],
                     rec.value,
                     rec.size,
                     rec.tag,
                     rec.kind};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumGlobals; i++) begin
            glob_ff[i] <= '0;
         end
         sp_ff        <= '0;
         nest_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NumGlobals; i++) begin
            glob_ff[i] <= glob_in[i];
         end
         sp_ff   <= sp_in;
         nest_ff <= nest_in;
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= out_data_in;
         out_last_ff <= rec.last;
      end
   end

`ifndef SYNTHESIS
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpW'(STACK_DEPTH - 1))
      else $error("stack pointer beyond stack depth");

   a_nest_range: assert property (@(posedge clock) disable iff (reset)
      nest_ff <= NestW'(MAX_NEST))
      else $error("nesting depth beyond limit");

   a_push_advances: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> sp_ff == $past(sp_ff) + 1'b1)
      else $error("push did not advance the stack pointer");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (take && status == StUnder) |-> (sp_ff == '0 && sp_in == '0))
      else $error("pop underflow reported on a non-empty stack");
`endif

endmodule

// ----- hw/rtl/hid_descriptor_item_parser_top.sv -----
// Top level of the HID report descriptor item parser.
// Depends on hdip_pkg, hdip_front, hdip_queue and hdip_back.
//
// Feed the report descriptor one byte per word on req_; the block returns one
// word on rsp_ for each completed short item, each skipped long item, and each
// item cut off by a byte marked tlast. The byte path accepts one byte every
// clock cycle while the record queue has room, including while a result
// waits on rsp_tready; a result passes through the record queue and then
// the output register on its way to rsp_. Back-pressure holds
// only once the two-entry queue and the output register are full. Global
// items update the ten stored globals, Push and Pop move them through a stack
// memory of STACK_DEPTH-1 rows, one row of all ten globals written or read per
// cycle, and Collection/End Collection track nesting up to MAX_NEST. After a
// byte with tlast the parse state returns to the prefix, while globals, stack
// and nesting persist until reset. No clearing pass runs after reset; the
// stack memory is only read at rows a Push has written.
module hid_descriptor_item_parser_top
   import hdip_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = StackDepthDef,
   parameter int unsigned MAX_NEST    = MaxNestDef
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // last_byte
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [1:0] item_type, [9:2] item_tag, [17:10] item_size, [49:18] item_value,
   // [53:50] nest_level, [56:54] stack_level, [59:57] status,
   // [91:60] usage_page, [123:92] report ID, [155:124] report field size,
   // [187:156] report field count, [191:188] zero
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tlast    // end_of_descriptor
);

   logic    front_valid;
   rec_type front_rec;
   logic    front_ready;
   logic    back_valid;
   rec_type back_rec;
   logic    back_ready;

   // byte walker: prefix, short data, long size/tag/payload
   hdip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .rec_valid (front_valid),
      .rec       (front_rec),
      .rec_ready (front_ready)
   );

   // decouple the byte path from result back-pressure
   hdip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_rec   (front_rec),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_rec    (back_rec),
      .pop_ready  (back_ready)
   );

   // globals, stack, nesting and the result register
   hdip_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_NEST    (MAX_NEST)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (back_valid),
      .rec       (back_rec),
      .rec_ready (back_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule
